// ----- src/crfe_pkg.sv -----
// shared types, codes and helpers of the clipped rectangle fill engine
`default_nettype none
package crfe_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DIM_W          = 7;
	localparam int CNT_W          = 13;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_HLINE  = 3'd1;
	localparam logic [2:0] OP_VLINE  = 3'd2;
	localparam logic [2:0] OP_RECT   = 3'd3;
	localparam logic [2:0] OP_FRAME  = 3'd4;
	localparam logic [2:0] OP_COPY   = 3'd5;
	localparam logic [2:0] OP_READ   = 3'd6;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	localparam logic [2:0] FRAME_LAST_SEG = 3'd4;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		SEG_CLEAR,
		SEG_HLINE,
		SEG_VLINE,
		SEG_RECT,
		SEG_FR_FILL,
		SEG_FR_LEFT,
		SEG_FR_RIGHT,
		SEG_FR_TOP,
		SEG_FR_BOT,
		SEG_COPY,
		SEG_READ
	} seg_kind_t;

	typedef struct packed {
		logic      capture;
		logic      load;
		seg_kind_t kind;
		logic      write;
		logic      wr_copy;
		logic      read;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       empty;
		logic       last;
	} status_t;

	function automatic seg_kind_t seg_kind(input logic [2:0] op, input logic [2:0] idx);
		seg_kind_t k;
		k = SEG_CLEAR;
		case (op)
			OP_CLEAR: k = SEG_CLEAR;
			OP_HLINE: k = SEG_HLINE;
			OP_VLINE: k = SEG_VLINE;
			OP_RECT:  k = SEG_RECT;
			OP_FRAME: begin
				case (idx)
					3'd0:    k = SEG_FR_FILL;
					3'd1:    k = SEG_FR_LEFT;
					3'd2:    k = SEG_FR_RIGHT;
					3'd3:    k = SEG_FR_TOP;
					default: k = SEG_FR_BOT;
				endcase
			end
			OP_COPY:  k = SEG_COPY;
			OP_READ:  k = SEG_READ;
			default:  k = SEG_CLEAR;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- src/crfe_ctrl.sv -----
// command sequencer: walks the segments of a command and drives the datapath
`default_nettype none
module crfe_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire crfe_pkg::status_t status,
	output crfe_pkg::cmd_t        cmd
);
	import crfe_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_FILL  = 7'b0000100,
		ST_CP_RD = 7'b0001000,
		ST_CP_WR = 7'b0010000,
		ST_RD    = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] seg_idx_q, seg_idx_d;
	logic       out_valid_q;
	logic       more_segs;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign more_segs = (status.opcode == OP_FRAME) && (seg_idx_q != FRAME_LAST_SEG);

	always_comb begin
		state_d   = state_q;
		seg_idx_d = seg_idx_q;
		cmd       = '0;
		cmd.kind  = seg_kind(status.opcode, seg_idx_q);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					seg_idx_d   = 3'd0;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				cmd.load = 1'b1;
				case (status.opcode)
					OP_CLEAR, OP_HLINE, OP_VLINE, OP_RECT, OP_FRAME: state_d = ST_FILL;
					OP_COPY: state_d = ST_CP_RD;
					OP_READ: state_d = ST_RD;
					default: begin
						cmd.load = 1'b0;
						state_d  = ST_DONE;
					end
				endcase
			end
			ST_FILL: begin
				if (status.empty || status.last) begin
					if (more_segs) begin
						seg_idx_d = seg_idx_q + 3'd1;
						state_d   = ST_START;
					end else begin
						state_d = ST_DONE;
					end
				end
				cmd.write = !status.empty;
			end
			ST_CP_RD: begin
				if (status.empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.read = 1'b1;
					state_d  = ST_CP_WR;
				end
			end
			ST_CP_WR: begin
				cmd.write   = 1'b1;
				cmd.wr_copy = 1'b1;
				state_d     = status.last ? ST_DONE : ST_CP_RD;
			end
			ST_RD: begin
				cmd.read = !status.empty;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seg_idx_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			seg_idx_q <= seg_idx_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/crfe_dp.sv -----
// datapath: config registers, segment clipping, pixel walker, frame store, result
`default_nettype none
module crfe_dp #(
	parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [6:0]           cfg_data,
	input  wire logic [2:0]           opcode,
	input  wire logic signed [15:0]   x_first,
	input  wire logic signed [15:0]   y_first,
	input  wire logic signed [15:0]   x_second,
	input  wire logic signed [15:0]   y_second,
	input  wire logic [31:0]          fill_color,
	input  wire logic [31:0]          outline_color,
	input  wire crfe_pkg::cmd_t       cmd,
	output crfe_pkg::status_t         status,
	output logic [31:0]               read_data,
	output logic                      rejected,
	output logic [12:0]               pixels_written
);
	import crfe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0] cfg_w_q, cfg_h_q, eff_w, eff_h;

	logic [2:0]         op_q;
	logic signed [15:0] x1_q, y1_q, x2_q, y2_q;
	logic [31:0]        cf_q, co_q;

	logic signed [17:0] sx1, sy1, sx2, sy2, w18, h18;
	logic signed [17:0] xa, xb, ya, yb, tmp, xlo, xhi, ylo, yhi;
	logic               swap_x, swap_y, seg_empty, copy_bad, read_bad, rej;
	logic [13:0]        prod, src_prod;
	logic [31:0]        seg_color;

	logic [DIM_W-1:0] x_q, xa_q, xb_q, y_q, yb_q;
	logic [AW-1:0]    base_q, src_base_q, wr_addr, rd_addr;
	logic             empty_q;
	logic [31:0]      color_q, mem_rd_q, wdata;
	logic [CNT_W-1:0] cnt_q;

	logic [31:0] mem [DEPTH];

	always_comb begin
		if (cfg_w_q == '0) eff_w = 7'd1;
		else if (int'(cfg_w_q) > MAX_WIDTH) eff_w = DIM_W'(MAX_WIDTH);
		else eff_w = cfg_w_q;
		if (cfg_h_q == '0) eff_h = 7'd1;
		else if (int'(cfg_h_q) > MAX_HEIGHT) eff_h = DIM_W'(MAX_HEIGHT);
		else eff_h = cfg_h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= DIM_RESET;
			cfg_h_q <= DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_WIDTH) cfg_w_q <= cfg_data;
			if (cfg_index == REG_HEIGHT) cfg_h_q <= cfg_data;
		end
	end

	// segment bounds, inclusive, before clipping
	always_comb begin
		sx1 = 18'(x1_q);
		sy1 = 18'(y1_q);
		sx2 = 18'(x2_q);
		sy2 = 18'(y2_q);
		w18 = signed'({11'b0, eff_w});
		h18 = signed'({11'b0, eff_h});
		swap_x    = 1'b0;
		swap_y    = 1'b0;
		seg_color = cf_q;
		tmp = '0;
		xa = sx1;
		xb = sx1;
		ya = sy1;
		yb = sy1;
		case (cmd.kind)
			SEG_CLEAR: begin
				xa = '0; xb = w18 - 18'sd1; ya = '0; yb = h18 - 18'sd1;
			end
			SEG_HLINE: begin
				xb = sx2; swap_x = 1'b1;
			end
			SEG_VLINE: begin
				yb = sy2; swap_y = 1'b1;
			end
			SEG_RECT: begin
				xb = sx2 - 18'sd1; yb = sy2 - 18'sd1;
			end
			SEG_FR_FILL: begin
				xa = sx1 + 18'sd1; xb = sx2 - 18'sd2;
				ya = sy1 + 18'sd1; yb = sy2 - 18'sd2;
			end
			SEG_FR_LEFT: begin
				yb = sy2 - 18'sd1; swap_y = 1'b1; seg_color = co_q;
			end
			SEG_FR_RIGHT: begin
				xa = sx2 - 18'sd1; xb = sx2 - 18'sd1;
				yb = sy2 - 18'sd1; swap_y = 1'b1; seg_color = co_q;
			end
			SEG_FR_TOP: begin
				xb = sx2 - 18'sd1; swap_x = 1'b1; seg_color = co_q;
			end
			SEG_FR_BOT: begin
				xb = sx2 - 18'sd1; ya = sy2 - 18'sd1; yb = sy2 - 18'sd1;
				swap_x = 1'b1; seg_color = co_q;
			end
			SEG_COPY: begin
				xa = '0; xb = w18 - 18'sd1; ya = sy2; yb = sy2;
			end
			SEG_READ: begin
				xa = sx1;
			end
			default: begin
				xa = sx1;
			end
		endcase
		if (swap_x && xa > xb) begin
			tmp = xa; xa = xb; xb = tmp;
		end
		if (swap_y && ya > yb) begin
			tmp = ya; ya = yb; yb = tmp;
		end
		xlo = (xa < 18'sd0) ? 18'sd0 : xa;
		xhi = (xb > w18 - 18'sd1) ? w18 - 18'sd1 : xb;
		ylo = (ya < 18'sd0) ? 18'sd0 : ya;
		yhi = (yb > h18 - 18'sd1) ? h18 - 18'sd1 : yb;
		copy_bad = (sy1 < 18'sd0) || (sy1 >= h18) || (sy2 < 18'sd0) || (sy2 >= h18)
			|| (sy1 == sy2);
		read_bad = (sx1 < 18'sd0) || (sx1 >= w18) || (sy1 < 18'sd0) || (sy1 >= h18);
		seg_empty = (xlo > xhi) || (ylo > yhi) || ((cmd.kind == SEG_COPY) && copy_bad);
		prod     = ylo[DIM_W-1:0] * eff_w;
		src_prod = y1_q[DIM_W-1:0] * eff_w;
	end

	always_comb begin
		case (op_q)
			OP_CLEAR: rej = 1'b0;
			OP_HLINE, OP_VLINE, OP_FRAME: rej = (cnt_q == '0);
			OP_RECT: rej = !((sx1 < w18) && (sx2 > 18'sd0) && (sy1 < h18) && (sy2 > 18'sd0));
			OP_COPY: rej = copy_bad;
			OP_READ: rej = read_bad;
			default: rej = 1'b1;
		endcase
	end

	assign wr_addr = base_q + AW'(x_q);
	assign rd_addr = src_base_q + AW'(x_q);
	assign wdata   = cmd.wr_copy ? mem_rd_q : color_q;

	assign status.opcode = op_q;
	assign status.empty  = empty_q;
	assign status.last   = (x_q == xb_q) && (y_q == yb_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= opcode;
			x1_q <= x_first;
			y1_q <= y_first;
			x2_q <= x_second;
			y2_q <= y_second;
			cf_q <= fill_color;
			co_q <= outline_color;
		end
		if (cmd.load) begin
			x_q        <= xlo[DIM_W-1:0];
			xa_q       <= xlo[DIM_W-1:0];
			xb_q       <= xhi[DIM_W-1:0];
			y_q        <= ylo[DIM_W-1:0];
			yb_q       <= yhi[DIM_W-1:0];
			base_q     <= AW'(prod);
			src_base_q <= AW'(src_prod);
			color_q    <= seg_color;
		end else if (cmd.write) begin
			// row-major walk, the row base advances by the active width
			if (x_q == xb_q) begin
				x_q    <= xa_q;
				y_q    <= y_q + 7'd1;
				base_q <= base_q + AW'(eff_w);
			end else begin
				x_q <= x_q + 7'd1;
			end
		end
		if (cmd.finish) begin
			read_data      <= (op_q == OP_READ && !rej) ? mem_rd_q : 32'd0;
			rejected       <= rej;
			pixels_written <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			if (cmd.load) empty_q <= seg_empty;
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.write && cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 13'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) mem[wr_addr] <= wdata;
		if (cmd.read) mem_rd_q <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ----- src/clipped_rect_fill_engine_top.sv -----
// top level of the clipped rectangle fill engine
`default_nettype none
// 2D drawing engine over a MAX_WIDTH x MAX_HEIGHT frame store of 32-bit ARGB pixels,
// addressed as y * width + x with the active width and height from the two config
// registers (clamped to 1..MAX). Commands are taken one at a time and each returns one
// result transaction. Fill-type commands write one pixel per cycle through the single
// store write port; each drawn segment starts with a setup step that loads its clipped
// bounds, and a segment that clips to nothing writes no pixel. A framed rectangle is
// drawn as five segments: the inner fill, then its left, right, top and bottom edges.
// A row copy moves each pixel through the one read and one write port, reading a
// pixel and writing it before it reads the next. The finish waits while an earlier
// result is still held by the receiver. The store powers up with undefined contents.
module clipped_rect_fill_engine_top #(
	parameter int MAX_WIDTH  = crfe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = crfe_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [6:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         opcode,
	input  wire logic signed [15:0] x_first,
	input  wire logic signed [15:0] y_first,
	input  wire logic signed [15:0] x_second,
	input  wire logic signed [15:0] y_second,
	input  wire logic [31:0]        fill_color,
	input  wire logic [31:0]        outline_color,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             read_data,
	output logic                    rejected,
	output logic [12:0]             pixels_written
);
	import crfe_pkg::*;

	cmd_t    cmd;
	status_t status;

	crfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	crfe_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.x_first        (x_first),
		.y_first        (y_first),
		.x_second       (x_second),
		.y_second       (y_second),
		.fill_color     (fill_color),
		.outline_color  (outline_color),
		.cmd            (cmd),
		.status         (status),
		.read_data      (read_data),
		.rejected       (rejected),
		.pixels_written (pixels_written)
	);

	// no store traffic while waiting for a new command
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !(cmd.write || cmd.read))
		else $error("store access while idle");

	// a pixel write only happens inside a non-empty segment
	a_write_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !status.empty)
		else $error("write in empty segment");

	// a result is only loaded when the output register is free
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid || out_ready))
		else $error("result overwritten");

	// a new result shows up only after a finish
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("result valid without finish");

endmodule
`default_nettype wire

// ----- bench/tb_clipped_rect_fill_engine_top.sv -----
// self-checking testbench of the clipped rectangle fill engine with a built-in drawing predictor
`default_nettype none
module tb_clipped_rect_fill_engine_top;
	import crfe_pkg::*;

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic [31:0]        fc;
		logic [31:0]        oc;
	} draw_cmd_t;

	typedef struct {
		logic [31:0] data;
		logic        rej;
		logic [12:0] count;
	} draw_result_t;

	localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int CYCLE_LIMIT = 50_000_000;

	logic clk, arst_n;
	logic cfg_we, cfg_index;
	logic [6:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] opcode;
	logic signed [15:0] x_first, y_first, x_second, y_second;
	logic [31:0] fill_color, outline_color, read_data;
	logic rejected;
	logic [12:0] pixels_written;

	clipped_rect_fill_engine_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.x_first(x_first), .y_first(y_first), .x_second(x_second), .y_second(y_second),
		.fill_color(fill_color), .outline_color(outline_color), .out_valid(out_valid),
		.out_ready(out_ready), .read_data(read_data), .rejected(rejected),
		.pixels_written(pixels_written)
	);

	logic [31:0] pixel_mem [STORE_DEPTH];
	logic [6:0] width_reg, height_reg;
	int act_w, act_h, px_count;
	draw_cmd_t cmd_backlog[$];
	draw_result_t exp_results[$];
	draw_cmd_t cur_cmd;
	int idle_mode;    // 0 none, 1 sender, 2 receiver, 3 both
	int results_seen, stall_left, cycles;
	bit held_once, failed;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void put_px(int x, int y, logic [31:0] c);
		pixel_mem[y * act_w + x] = c;
		px_count++;
	endfunction

	function automatic void draw_hline(int y, int a, int b, logic [31:0] c);
		int t;
		if (y < 0 || y >= act_h) return;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (a < 0) a = 0;
		if (b > act_w - 1) b = act_w - 1;
		for (int x = a; x <= b; x++) put_px(x, y, c);
	endfunction

	function automatic void draw_vline(int x, int a, int b, logic [31:0] c);
		int t;
		if (x < 0 || x >= act_w) return;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (a < 0) a = 0;
		if (b > act_h - 1) b = act_h - 1;
		for (int y = a; y <= b; y++) put_px(x, y, c);
	endfunction

	function automatic bit draw_rect(int l, int t, int r, int b, logic [31:0] c);
		if (!(l < act_w && r > 0 && t < act_h && b > 0)) return 0;
		if (l < 0) l = 0;
		if (t < 0) t = 0;
		if (r > act_w) r = act_w;
		if (b > act_h) b = act_h;
		for (int y = t; y < b; y++)
			for (int x = l; x < r; x++) put_px(x, y, c);
		return 1;
	endfunction

	function automatic draw_result_t draw_predict(draw_cmd_t c);
		draw_result_t res;
		int x1, y1, x2, y2;
		x1 = $signed(c.x1);
		y1 = $signed(c.y1);
		x2 = $signed(c.x2);
		y2 = $signed(c.y2);
		act_w = (width_reg < 1) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		act_h = (height_reg < 1) ? 1 :
			(height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
		px_count = 0;
		res.data = '0;
		res.rej = 1'b0;
		case (c.op)
			OP_CLEAR: begin
				for (int y = 0; y < act_h; y++)
					for (int x = 0; x < act_w; x++) put_px(x, y, c.fc);
			end
			OP_HLINE: begin
				draw_hline(y1, x1, x2, c.fc);
				res.rej = (px_count == 0);
			end
			OP_VLINE: begin
				draw_vline(x1, y1, y2, c.fc);
				res.rej = (px_count == 0);
			end
			OP_RECT: res.rej = !draw_rect(x1, y1, x2, y2, c.fc);
			OP_FRAME: begin
				void'(draw_rect(x1 + 1, y1 + 1, x2 - 1, y2 - 1, c.fc));
				draw_vline(x1, y1, y2 - 1, c.oc);
				draw_vline(x2 - 1, y1, y2 - 1, c.oc);
				draw_hline(y1, x1, x2 - 1, c.oc);
				draw_hline(y2 - 1, x1, x2 - 1, c.oc);
				res.rej = (px_count == 0);
			end
			OP_COPY: begin
				if (y1 < 0 || y1 >= act_h || y2 < 0 || y2 >= act_h || y1 == y2)
					res.rej = 1'b1;
				else
					for (int x = 0; x < act_w; x++) put_px(x, y2, pixel_mem[y1 * act_w + x]);
			end
			OP_READ: begin
				if (x1 < 0 || x1 >= act_w || y1 < 0 || y1 >= act_h) res.rej = 1'b1;
				else res.data = pixel_mem[y1 * act_w + x1];
			end
			default: res.rej = 1'b1;
		endcase
		res.count = (px_count > 8191) ? 13'd8191 : px_count[12:0];
		return res;
	endfunction

	// coordinate mostly near the active range, sometimes anywhere in 16 bits
	function automatic logic signed [15:0] pick_coord(int lim);
		if ($urandom_range(99) < 10) return 16'($urandom);
		return 16'(int'($urandom_range(lim + 4)) - 2);
	endfunction

	function automatic draw_cmd_t random_cmd(int w, int h);
		draw_cmd_t c;
		int r;
		r = $urandom_range(99);
		c.op = (r < 2) ? OP_CLEAR : (r < 16) ? OP_HLINE : (r < 30) ? OP_VLINE :
			(r < 46) ? OP_RECT : (r < 60) ? OP_FRAME : (r < 72) ? OP_COPY :
			(r < 97) ? OP_READ : OP_UNUSED;
		c.x1 = pick_coord(w);
		c.y1 = pick_coord(h);
		c.x2 = ($urandom_range(9) == 0) ? pick_coord(w) :
			16'(int'(c.x1) + int'($urandom_range(20)) - 4);
		c.y2 = ($urandom_range(9) == 0) ? pick_coord(h) :
			16'(int'(c.y1) + int'($urandom_range(20)) - 4);
		if (c.op == OP_COPY) c.y2 = pick_coord(h);
		c.fc = $urandom;
		c.oc = $urandom;
		return c;
	endfunction

	function automatic draw_cmd_t mk(logic [2:0] op, int x1, int y1, int x2, int y2,
		logic [31:0] fc, logic [31:0] oc);
		draw_cmd_t c;
		c.op = op; c.x1 = 16'(x1); c.y1 = 16'(y1); c.x2 = 16'(x2); c.y2 = 16'(y2);
		c.fc = fc; c.oc = oc;
		return c;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0; x_first <= '0; y_first <= '0; x_second <= '0; y_second <= '0;
			fill_color <= '0; outline_color <= '0;
		end else begin : drive
			logic nv;
			nv = in_valid;
			if (in_valid && in_ready) begin
				exp_results.push_back(draw_predict(cur_cmd));
				nv = 1'b0;
			end
			if (!nv && cmd_backlog.size() > 0 &&
			    !((idle_mode == 1 && $urandom_range(99) < 79) ||
			      (idle_mode == 3 && $urandom_range(99) < 6))) begin
				cur_cmd = cmd_backlog.pop_front();
				opcode <= cur_cmd.op;
				x_first <= cur_cmd.x1;
				y_first <= cur_cmd.y1;
				x_second <= cur_cmd.x2;
				y_second <= cur_cmd.y2;
				fill_color <= cur_cmd.fc;
				outline_color <= cur_cmd.oc;
				nv = 1'b1;
			end
			in_valid <= nv;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			held_once <= 1'b0;
		end else begin : check
			draw_result_t e;
			if (out_valid && out_ready) begin
				results_seen++;
				if (exp_results.size() == 0) begin
					$error("result transaction with nothing expected");
					failed = 1'b1;
				end else begin
					e = exp_results.pop_front();
					if (read_data !== e.data) begin
						$error("read_data expected %h actual %h", e.data, read_data);
						failed = 1'b1;
					end
					if (rejected !== e.rej) begin
						$error("rejected expected %b actual %b", e.rej, rejected);
						failed = 1'b1;
					end
					if (pixels_written !== e.count) begin
						$error("pixels_written expected %0d actual %0d", e.count, pixels_written);
						failed = 1'b1;
					end
				end
			end
			// one long hold-off so the input side backs up
			if (!held_once && results_seen == 40) begin
				held_once <= 1'b1;
				stall_left <= 600;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !((idle_mode == 2 && $urandom_range(99) < 79) ||
					(idle_mode == 3 && $urandom_range(99) < 6));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("clipped_rect_fill_engine_top: mismatch");
			$finish;
		end
	end

	task automatic write_dims(logic [6:0] w, logic [6:0] h);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT; cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
		height_reg = h;
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() > 0 || in_valid || exp_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic [6:0] widths [8] = '{64, 1, 127, 0, 17, 64, 33, 100};
		logic [6:0] heights [8] = '{64, 1, 0, 127, 9, 64, 40, 5};
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		width_reg = DIM_RESET; height_reg = DIM_RESET;
		idle_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 8; p++) begin
			write_dims(widths[p], heights[p]);
			idle_mode = p % 4;
			if (p == 0) begin
				// full clear first so every store entry holds a known value
				cmd_backlog.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 32'h0, 32'h0));
				cmd_backlog.push_back(mk(OP_HLINE, -32768, 0, 32767, 0, 32'hffff_ffff, 0));
				cmd_backlog.push_back(mk(OP_HLINE, 10, -1, 3, 0, 32'h1234_5678, 0));
				cmd_backlog.push_back(mk(OP_HLINE, 70, 5, 64, 0, 32'h1, 0));
				cmd_backlog.push_back(mk(OP_VLINE, 63, 40, -5, 0, 32'h8000_0000, 0));
				cmd_backlog.push_back(mk(OP_VLINE, 64, 0, 10, 0, 32'h2, 0));
				cmd_backlog.push_back(mk(OP_RECT, -32768, -32768, 32767, 32767,
					32'haaaa_5555, 0));
				cmd_backlog.push_back(mk(OP_RECT, 64, 0, 70, 5, 32'h3, 0));
				cmd_backlog.push_back(mk(OP_RECT, 0, 0, 0, 5, 32'h4, 0));
				cmd_backlog.push_back(mk(OP_RECT, 20, 20, 10, 10, 32'h5, 0));
				cmd_backlog.push_back(mk(OP_RECT, 0, 64, 5, 70, 32'h6, 0));
				cmd_backlog.push_back(mk(OP_FRAME, 2, 3, 12, 9, 32'h00ff_00ff, 32'hff00_ff00));
				cmd_backlog.push_back(mk(OP_FRAME, 7, 7, 8, 8, 32'h7, 32'h8));
				cmd_backlog.push_back(mk(OP_FRAME, -10, -10, 0, 0, 32'h9, 32'ha));
				cmd_backlog.push_back(mk(OP_FRAME, -32768, -32768, 32767, 32767, 0, 32'hffff_ffff));
				cmd_backlog.push_back(mk(OP_COPY, 0, 3, 0, 63, 0, 0));
				cmd_backlog.push_back(mk(OP_COPY, 0, 4, 0, 4, 0, 0));
				cmd_backlog.push_back(mk(OP_COPY, 0, -1, 0, 4, 0, 0));
				cmd_backlog.push_back(mk(OP_COPY, 0, 4, 0, 64, 0, 0));
				cmd_backlog.push_back(mk(OP_READ, 5, 3, 0, 0, 0, 0));
				cmd_backlog.push_back(mk(OP_READ, 63, 63, 0, 0, 0, 0));
				cmd_backlog.push_back(mk(OP_READ, -1, 0, 0, 0, 0, 0));
				cmd_backlog.push_back(mk(OP_READ, 0, 64, 0, 0, 0, 0));
				cmd_backlog.push_back(mk(OP_UNUSED, 1, 1, 2, 2, 32'hffff_ffff, 32'hffff_ffff));
			end
			for (int i = 0; i < 170; i++)
				cmd_backlog.push_back(random_cmd(widths[p] > 64 ? 64 : widths[p],
					heights[p] > 64 ? 64 : heights[p]));
			wait_drained();
		end
		repeat (50) @(posedge clk);
		if (failed)
			$display("clipped_rect_fill_engine_top: mismatch");
		else
			$display("clipped_rect_fill_engine_top: match");
		$finish;
	end

endmodule
`default_nettype wire
